>>> rtl/sipq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted-insertion min priority queue.
// Used by sipq_cell and sorted_insert_min_priority_queue; depends on nothing.
package sipq_pkg;

  // Width of one stored value.
  localparam int unsigned DATA_W = 32;

  // Operation codes on the mode field; the unused code behaves as a query.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Status codes returned with every result item.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

  // Head value reported while the queue is empty.
  localparam logic signed [DATA_W-1:0] EMPTY_HEAD = '1;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // insert data_value, queue known not full
    logic pop;    // drop the front entry, queue known not empty
  } sipq_ctl_t;

endpackage

>>> rtl/sipq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted shift chain: holds a single entry and decides
// locally whether to keep it, take the new value, or shift. Uses sipq_pkg.
module sipq_cell (
  input  logic                              clk,
  input  sipq_pkg::sipq_ctl_t               ctl,
  input  logic                              occupied,
  input  logic signed [sipq_pkg::DATA_W-1:0] data_value,
  input  logic signed [sipq_pkg::DATA_W-1:0] left_value,
  input  logic                              left_lt,
  input  logic signed [sipq_pkg::DATA_W-1:0] right_value,
  output logic signed [sipq_pkg::DATA_W-1:0] value,
  output logic                              lt
);
  import sipq_pkg::*;

  logic signed [DATA_W-1:0] value_next;

  // An occupied entry strictly smaller than the new value stays in place.
  assign lt = occupied && (value < data_value);

  // Since the chain is ascending, lt is true on a prefix of cells. The first
  // cell outside that prefix takes the new value; the rest shift right.
  always_comb begin
    value_next = value;
    if (ctl.push) begin
      if (lt) begin
        value_next = value;
      end else if (left_lt) begin
        value_next = data_value;
      end else begin
        value_next = left_value;
      end
    end else if (ctl.pop) begin
      value_next = right_value;
    end
  end

  // Entry register; contents are meaningful only below the fill count.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> rtl/sorted_insert_min_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted-insertion min priority queue: a chain of sipq_cell
// instances plus the fill count and the result register. Uses sipq_pkg.

// The queue keeps up to CAPACITY signed 32-bit values in ascending order in a
// chain of cells, one entry per cell. A push is inserted ahead of the first
// entry that is not smaller, so equal values leave in reverse arrival order; a pop
// removes the smallest; a query (or the unused mode code) changes nothing.
// Each input item yields one result item carrying the head after the step
// (-1 when empty), an empty flag, the entry count (modulo 32) and a status.
// Every cell compares against the new value in parallel and the chain shifts
// in the same cycle, so an item is accepted on every clock while the result
// register is free or being emptied: one item per cycle, result in the cycle
// after acceptance. The result register is the only limit on throughput.
module sorted_insert_min_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         mode,
  input  logic signed [sipq_pkg::DATA_W-1:0] data_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sipq_pkg::DATA_W-1:0] head_value,
  output logic                               is_empty,
  output logic [4:0]                         entry_count,
  output logic [1:0]                         status
);
  import sipq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                     in_accept;
  logic                     full;
  logic                     empty;
  sipq_ctl_t                ctl;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [1:0]               status_next;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_lt    [CAPACITY];

  // Handshake: the result register frees up as soon as it is taken.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Decode the operation and its effect on the fill count.
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = STATUS_OK;
    if (in_accept) begin
      unique case (mode)
        MODE_PUSH: begin
          if (full) begin
            status_next = STATUS_PUSH_FULL;
          end else begin
            ctl.push   = 1'b1;
            count_next = count + 1'b1;
          end
        end
        MODE_POP: begin
          if (empty) begin
            status_next = STATUS_POP_EMPTY;
          end else begin
            ctl.pop    = 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: begin
          status_next = STATUS_OK;
        end
      endcase
    end
  end

  // The cell chain. Cell 0 sees a "smaller" left neighbor so it takes the
  // new value whenever its own entry is not smaller; the last cell refills
  // from itself on a pop, which leaves a don't-care entry past the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic                     left_l;
    logic signed [DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = data_value;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
      assign left_l = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    sipq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (count > CNT_W'(i)),
      .data_value  (data_value),
      .left_value  (left_v),
      .left_lt     (left_l),
      .right_value (right_v),
      .value       (cell_value[i]),
      .lt          (cell_lt[i])
    );
  end

  // Fill count, result status and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      status    <= STATUS_OK;
    end else begin
      count <= count_next;
      if (in_accept) begin
        out_valid <= 1'b1;
        status    <= status_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The state only moves on acceptance, so the result reads it directly.
  assign is_empty    = empty;
  assign head_value  = empty ? EMPTY_HEAD : cell_value[0];
  assign entry_count = 5'(count);

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A push that is not dropped adds exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode == MODE_PUSH && !full) |=> count == $past(count) + 1'b1)
    else $error("push did not add one entry");

  // A push is flagged as dropped only when the queue was full.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_PUSH_FULL) |-> full)
    else $error("push-full status with room left");

  // A pop is flagged as ignored only when the queue is empty.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_POP_EMPTY) |-> empty)
    else $error("pop-empty status on a non-empty queue");

endmodule

>>> dv/sorted_insert_min_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_insert_min_priority_queue: push, pop and query
// items against a software copy of the sorted queue. Depends on sipq_pkg and the RTL.
module sorted_insert_min_priority_queue_tb;
  import sipq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned STALL_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS = 775;
  localparam int unsigned BURST_LEN    = 24;

  // The spare mode code; the block treats it as a query.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Pacing of the two channels, carried along with each item.
  typedef enum logic [1:0] {
    PACE_RX_HEAVY,
    PACE_TX_HEAVY,
    PACE_NONE
  } pace_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    pace_t                    pace;
    bit                       wait_drain;
    bit                       stall_out;
  } queue_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] head;
    logic                     none_held;
    logic [4:0]               count;
    logic [1:0]               status;
  } queue_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                mode = MODE_QUERY;
  logic signed [DATA_W-1:0]  data_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DATA_W-1:0]  head_value;
  logic                      is_empty;
  logic [4:0]                entry_count;
  logic [1:0]                status;

  // Pacing and stall request handed from the driver to the receiver.
  pace_t                     cur_pace = PACE_RX_HEAVY;
  logic                      stall_req = 1'b0;

  queue_cmd_t                pending_cmds[$];
  queue_result_t             expected_results[$];

  // Software copy of the queue contents, ascending.
  logic signed [DATA_W-1:0]  held [QUEUE_DEPTH];
  int unsigned               held_count = 0;

  int unsigned               mismatches = 0;
  int unsigned               cycle_count = 0;
  int unsigned               hold_left = 0;
  bit                        stall_done = 1'b0;

  sorted_insert_min_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .data_value (data_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head_value (head_value),
    .is_empty   (is_empty),
    .entry_count(entry_count),
    .status     (status)
  );

  always #4 clk = ~clk;

  // Applies one operation to the software queue and returns what the block should report.
  function automatic queue_result_t step_queue(logic [1:0] op, logic signed [DATA_W-1:0] value);
    queue_result_t res;
    int unsigned   pos;
    res.status = STATUS_OK;
    if (op == MODE_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = STATUS_PUSH_FULL;
      end else begin
        // Insert ahead of the first entry that is not smaller.
        pos = 0;
        while (pos < held_count && held[pos] < value) pos++;
        for (int k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos] = value;
        held_count++;
      end
    end else if (op == MODE_POP) begin
      if (held_count == 0) begin
        res.status = STATUS_POP_EMPTY;
      end else begin
        for (int k = 1; k < held_count; k++) held[k-1] = held[k];
        held_count--;
      end
    end
    res.head      = (held_count == 0) ? EMPTY_HEAD : held[0];
    res.none_held = (held_count == 0);
    res.count     = held_count[4:0];
    return res;
  endfunction

  function automatic int unsigned tx_idle_pct(pace_t p);
    case (p)
      PACE_RX_HEAVY: return 16;
      PACE_TX_HEAVY: return 56;
      default:       return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct(pace_t p);
    case (p)
      PACE_RX_HEAVY: return 56;
      PACE_TX_HEAVY: return 16;
      default:       return 0;
    endcase
  endfunction

  task automatic add_cmd(logic [1:0] op, logic signed [DATA_W-1:0] value, pace_t pace,
                         bit wait_drain = 1'b0, bit stall_out = 1'b0);
    queue_cmd_t cmd;
    cmd.op         = op;
    cmd.value      = value;
    cmd.pace       = pace;
    cmd.wait_drain = wait_drain;
    cmd.stall_out  = stall_out;
    pending_cmds.insert(pending_cmds.size(), cmd);
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Driver: predicts on every accepted item, then offers the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      stall_req <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), step_queue(mode, data_value));
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].wait_drain && expected_results.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct(pending_cmds[0].pace)) begin
          in_valid   <= 1'b1;
          mode       <= pending_cmds[0].op;
          data_value <= pending_cmds[0].value;
          cur_pace   <= pending_cmds[0].pace;
          stall_req  <= pending_cmds[0].stall_out;
          pending_cmds.delete(0);
        end else begin
          in_valid  <= 1'b0;
          stall_req <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      hold_left  = STALL_CYCLES - 1;
      stall_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct(cur_pace));
    end
  end

  // Monitor: each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result: head=%0d empty=%0b count=%0d status=%0d",
                               head_value, is_empty, entry_count, status));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (want.head !== head_value)
          log_mismatch($sformatf("head_value: expected %0d, got %0d", want.head, head_value));
        if (want.none_held !== is_empty)
          log_mismatch($sformatf("is_empty: expected %0b, got %0b", want.none_held, is_empty));
        if (want.count !== entry_count)
          log_mismatch($sformatf("entry_count: expected %0d, got %0d", want.count, entry_count));
        if (want.status !== status)
          log_mismatch($sformatf("status: expected %0d, got %0d", want.status, status));
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    int unsigned              push_bias;
    int unsigned              roll;
    pace_t                    pace;

    // Directed: empty-queue cases, fill past capacity with extremes and duplicates.
    add_cmd(MODE_POP,   32'sd9, PACE_RX_HEAVY);
    add_cmd(MODE_QUERY, 32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_SPARE, 32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  VAL_MAX, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  VAL_MIN, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  -32'sd1, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd1, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  -32'sd2, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  VAL_MAX, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  VAL_MIN, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd5, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  -32'sd5, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd100, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  -32'sd100, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sh5555_5555, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'shAAAA_AAAA, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd7, PACE_RX_HEAVY);
    add_cmd(MODE_PUSH,  32'sd3, PACE_RX_HEAVY);
    add_cmd(MODE_QUERY, 32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_SPARE, 32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_POP,   32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_POP,   32'sd0, PACE_RX_HEAVY);
    add_cmd(MODE_POP,   32'sd0, PACE_RX_HEAVY);

    // Random: bursts that lean toward push or pop so the queue swings between
    // full and empty; values favor extremes and a narrow band for duplicates.
    push_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS / 3) pace = PACE_RX_HEAVY;
      else if (n < 2 * RANDOM_ITEMS / 3) pace = PACE_TX_HEAVY;
      else pace = PACE_NONE;
      if (n % BURST_LEN == 0) begin
        roll = $urandom_range(2);
        push_bias = (roll == 0) ? 85 : (roll == 1) ? 50 : 20;
      end
      roll = $urandom_range(99);
      if (roll < push_bias) op = MODE_PUSH;
      else if (roll < 96) op = MODE_POP;
      else if (roll < 98) op = MODE_QUERY;
      else op = MODE_SPARE;
      roll = $urandom_range(9);
      if (roll == 0) begin
        case ($urandom_range(3))
          0: value = VAL_MIN;
          1: value = VAL_MAX;
          2: value = -32'sd1;
          default: value = 32'sd0;
        endcase
      end else if (roll < 5) begin
        value = $signed($urandom_range(8)) - 32'sd4;
      end else begin
        value = $urandom;
      end
      // The sender waits for a full drain where the pacing changes; the long
      // receiver hold-off falls early in the full-rate stretch.
      add_cmd(op, value, pace,
              (n == RANDOM_ITEMS / 3) || (n == 2 * RANDOM_ITEMS / 3),
              (n == 2 * RANDOM_ITEMS / 3 + 20));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sipq_pkg.sv
rtl/sipq_cell.sv
rtl/sorted_insert_min_priority_queue.sv
dv/sorted_insert_min_priority_queue_tb.sv
